[hw/rtl/stepseq_pkg.sv]
// Shared types, constants and the coil decode for the two-axis stepper sequencer.
`default_nettype none
package stepseq_pkg;

    // Fixed sizes of the waypoint table and axis positions.
    localparam int MAX_WP = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int POS_W  = 16;

    // Input item modes.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // Configuration register indexes (paddr bit 2).
    localparam logic REG_WAYPOINT_COUNT = 1'b0;
    localparam logic REG_AXIS_INVERT    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0] RST_WAYPOINT_COUNT = CNT_W'(4);
    localparam logic [1:0]       RST_AXIS_INVERT    = 2'b01;

    // One write into the waypoint table.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_load;

    // Wave-drive order is coil1, coil3, coil2, coil4.
    function automatic logic [3:0] coil_of_phase(input logic [1:0] phase);
        logic [3:0] coils;
        case (phase)
            2'd0:    coils = 4'b0001;
            2'd1:    coils = 4'b0100;
            2'd2:    coils = 4'b0010;
            2'd3:    coils = 4'b1000;
            default: coils = 4'b0001;
        endcase
        return coils;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/stepseq_axis.sv]
// One stepper axis: position and wave-drive phase registers with the step logic.
`default_nettype none
module stepseq_axis
    import stepseq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick,
    input  wire logic [POS_W-1:0] i_target,
    input  wire logic             i_inv,
    output logic      [POS_W-1:0] o_pos_next,
    output logic      [3:0]       o_coils_next,
    output logic                  o_on_target
);

    logic [1:0]       r_phase;
    logic [POS_W-1:0] r_pos;
    logic [1:0]       n_phase;
    logic [POS_W-1:0] n_pos;

    // Step one place toward the target; the invert bit reverses the phase order.
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        if (r_pos < i_target) begin
            n_phase = i_inv ? (r_phase - 2'd1) : (r_phase + 2'd1);
            n_pos   = r_pos + POS_W'(1);
        end else if (r_pos > i_target) begin
            n_phase = i_inv ? (r_phase + 2'd1) : (r_phase - 2'd1);
            n_pos   = r_pos - POS_W'(1);
        end
    end

    // State only moves on a tick item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_pos   <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    assign o_pos_next   = n_pos;
    assign o_coils_next = coil_of_phase(n_phase);
    assign o_on_target  = (n_pos == i_target);

endmodule
`default_nettype wire

[hw/rtl/stepseq_wayp.sv]
// Waypoint table and the current waypoint index with its wrap logic.
`default_nettype none
module stepseq_wayp
    import stepseq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_load            i_load,
    input  wire logic             i_advance,
    input  wire logic [CNT_W-1:0] i_count,
    output logic      [POS_W-1:0] o_target_x,
    output logic      [POS_W-1:0] o_target_y,
    output logic      [IDX_W-1:0] o_ptr_next,
    output logic      [IDX_W-1:0] o_ptr
);

    logic [POS_W-1:0] r_tx [MAX_WP];
    logic [POS_W-1:0] r_ty [MAX_WP];
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] n_ptr;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] ptr_inc;

    // Table entries have no reset; each must be loaded before it is read, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (i_load.we) begin
            r_tx[i_load.idx] <= i_load.x;
            r_ty[i_load.idx] <= i_load.y;
        end
    end

    assign o_target_x = r_tx[r_ptr];
    assign o_target_y = r_ty[r_ptr];

    // A count of zero acts as one, and a count past the table acts as the table size.
    always_comb begin
        count_eff = i_count;
        if (i_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (i_count > CNT_W'(MAX_WP)) begin
            count_eff = CNT_W'(MAX_WP);
        end
        ptr_inc = {1'b0, r_ptr} + CNT_W'(1);
        n_ptr   = r_ptr;
        if (i_advance) begin
            n_ptr = (ptr_inc >= count_eff) ? '0 : ptr_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    assign o_ptr_next = n_ptr;
    assign o_ptr      = r_ptr;

endmodule
`default_nettype wire

[hw/rtl/two_axis_stepper_waypoint_sequencer_top.sv]
// Top level of the two-axis stepper waypoint sequencer.
//
// Usage: each input item is either a timer tick (mode 0) or a load of one
// waypoint table entry (mode 1). Items move on a valid/stall handshake; an
// item is taken at an edge where valid is high and stall is low. A tick
// steps each axis one place toward the current waypoint and yields exactly
// one result item with both coil patterns, positions, waypoint index and the
// blink level. A load writes the table and yields no result. Every entry must
// be loaded before a tick reads it.
// Path: an item lands in an input register, and its result is then written
// into the output register, from which it is offered to the receiver.
// Throughput is one item per cycle while the receiver does not stall; the
// step, compare and index update are combinational between the two registers.
// When the receiver stalls, the held result stays put, a waiting load still
// completes, and a waiting tick holds the input register, which then stalls
// the sender. Reset clears positions, phases (coil1 energized), the index and
// blink, and sets the waypoint count to 4 and the invert bits to X inverted.
// The table is not cleared. The user must write registers through the APB port
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none
module two_axis_stepper_waypoint_sequencer_top
    import stepseq_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input channel
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic         i_mode,
    input  wire logic [3:0]   i_load_index,
    input  wire logic [15:0]  i_load_x,
    input  wire logic [15:0]  i_load_y,
    // Result channel
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic      [3:0]   o_x_coils,
    output logic      [3:0]   o_y_coils,
    output logic      [15:0]  o_x_position,
    output logic      [15:0]  o_y_position,
    output logic      [3:0]   o_target_index,
    output logic              o_blink,
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    // Configuration registers
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_invert;

    // Input register
    logic             r_in_valid;
    logic             r_in_mode;
    logic [IDX_W-1:0] r_in_idx;
    logic [POS_W-1:0] r_in_x;
    logic [POS_W-1:0] r_in_y;

    // Output register
    logic             r_out_valid;
    logic [3:0]       r_out_xc;
    logic [3:0]       r_out_yc;
    logic [POS_W-1:0] r_out_xp;
    logic [POS_W-1:0] r_out_yp;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_blink;

    logic             in_accept;
    logic             do_load;
    logic             do_tick;
    logic             cfg_write;
    t_load            load;
    logic [POS_W-1:0] target_x;
    logic [POS_W-1:0] target_y;
    logic [POS_W-1:0] x_pos_next;
    logic [POS_W-1:0] y_pos_next;
    logic [3:0]       x_coils_next;
    logic [3:0]       y_coils_next;
    logic             x_on;
    logic             y_on;
    logic [IDX_W-1:0] ptr_next;
    logic [IDX_W-1:0] ptr_cur;

    // APB access; writes land on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= RST_WAYPOINT_COUNT;
            r_invert <= RST_AXIS_INVERT;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_WAYPOINT_COUNT: r_count  <= pwdata[CNT_W-1:0];
                REG_AXIS_INVERT:    r_invert <= pwdata[1:0];
                default:            r_count  <= r_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WAYPOINT_COUNT: prdata = 32'(r_count);
            REG_AXIS_INVERT:    prdata = 32'(r_invert);
            default:            prdata = '0;
        endcase
    end

    // A load always drains; a tick drains when the output register is free or being taken.
    assign do_load   = r_in_valid && (r_in_mode == MODE_LOAD);
    assign do_tick   = r_in_valid && (r_in_mode == MODE_TICK) && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !do_load && !do_tick;
    assign in_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (do_load || do_tick) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode <= i_mode;
            r_in_idx  <= i_load_index;
            r_in_x    <= i_load_x;
            r_in_y    <= i_load_y;
        end
    end

    assign load.we  = do_load;
    assign load.idx = r_in_idx;
    assign load.x   = r_in_x;
    assign load.y   = r_in_y;

    stepseq_wayp u_wayp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_advance  (do_tick && x_on && y_on),
        .i_count    (r_count),
        .o_target_x (target_x),
        .o_target_y (target_y),
        .o_ptr_next (ptr_next),
        .o_ptr      (ptr_cur)
    );

    stepseq_axis u_axis_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (do_tick),
        .i_target     (target_x),
        .i_inv        (r_invert[0]),
        .o_pos_next   (x_pos_next),
        .o_coils_next (x_coils_next),
        .o_on_target  (x_on)
    );

    stepseq_axis u_axis_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (do_tick),
        .i_target     (target_y),
        .i_inv        (r_invert[1]),
        .o_pos_next   (y_pos_next),
        .o_coils_next (y_coils_next),
        .o_on_target  (y_on)
    );

    // Output register and blink level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_blink     <= 1'b0;
        end else if (do_tick) begin
            r_out_valid <= 1'b1;
            r_blink     <= ~r_blink;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tick) begin
            r_out_xc  <= x_coils_next;
            r_out_yc  <= y_coils_next;
            r_out_xp  <= x_pos_next;
            r_out_yp  <= y_pos_next;
            r_out_idx <= ptr_next;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_x_coils      = r_out_xc;
    assign o_y_coils      = r_out_yc;
    assign o_x_position   = r_out_xp;
    assign o_y_position   = r_out_yp;
    assign o_target_index = r_out_idx;
    assign o_blink        = r_blink;

    // A shown result always drives exactly one coil per axis.
    a_coils_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($onehot(r_out_xc) && $onehot(r_out_yc)))
        else $error("coil pattern is not one-hot");

    // Blink toggles on every tick and only then.
    a_blink_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blink != $past(r_blink)) |-> $past(do_tick))
        else $error("blink changed without a tick");

    // A load never produces a result by itself.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_load && !r_out_valid) |=> !r_out_valid)
        else $error("load item produced a result");

    // The waypoint index moves only on a tick.
    a_ptr_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_tick |=> (ptr_cur == $past(ptr_cur)))
        else $error("waypoint index moved without a tick");

endmodule
`default_nettype wire
